### sv/sbas_pkg.sv
// Package for the signed BCD adder/subtractor.
// Holds widths, status codes and the stage record passed along the digit cells.
// No dependencies.
`timescale 1ns / 1ps

package sbas_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int DIG_W      = 4;
    localparam int MAG_W      = MAX_DIGITS * DIG_W;
    localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam int IN_DATA_W  = ((2 * MAG_W + 2 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((MAG_W + 3 + 7) / 8) * 8;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // One transaction in flight between two cells.
    typedef struct packed {
        logic [LEN_W-1:0] len;      // clamped length, 1..MAX_DIGITS
        logic             add;      // magnitudes are added, else subtracted
        logic             sign;     // sign of the result
        logic             bad;      // some used digit is above nine
        logic             carry;    // decimal carry or borrow into the next cell
        logic [MAG_W-1:0] big_mag;  // larger magnitude (or first operand on add)
        logic [MAG_W-1:0] sml_mag;  // smaller magnitude (or second operand on add)
        logic [MAG_W-1:0] sum;      // result digits filled in so far
    } t_stage;

endpackage

### sv/sbas_prep.sv
// Front stage: masks the operands to the length in use, resolves the
// effective signs and orders the magnitudes for subtraction. Uses sbas_pkg.
`timescale 1ns / 1ps

module sbas_prep
    import sbas_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_func,
    input  logic             i_a_sign,
    input  logic [MAG_W-1:0] i_a_digits,
    input  logic             i_b_sign,
    input  logic [MAG_W-1:0] i_b_digits,
    input  logic [LEN_W-1:0] i_cfg_len,
    output logic             o_valid,
    output t_stage           o_data
);

    logic             r_valid;
    t_stage           r_data;
    t_stage           n_data;
    logic [LEN_W-1:0] len;
    logic [MAG_W-1:0] mask;
    logic [MAG_W-1:0] x;
    logic [MAG_W-1:0] y;
    logic             sb;
    logic             y_gt_x;

    always_comb begin
        if (i_cfg_len == '0) begin
            len = LEN_W'(1);
        end else if (i_cfg_len > LEN_W'(MAX_DIGITS)) begin
            len = LEN_W'(MAX_DIGITS);
        end else begin
            len = i_cfg_len;
        end
        for (int k = 0; k < MAX_DIGITS; k++) begin
            mask[k*DIG_W +: DIG_W] = (LEN_W'(k) < len) ? {DIG_W{1'b1}} : '0;
        end
        x      = i_a_digits & mask;
        y      = i_b_digits & mask;
        sb     = i_b_sign ^ i_func;
        y_gt_x = y > x;

        n_data.len   = len;
        n_data.add   = (i_a_sign == sb);
        n_data.bad   = 1'b0;
        n_data.carry = 1'b0;
        n_data.sum   = '0;
        if (!n_data.add && y_gt_x) begin
            n_data.sign    = sb;
            n_data.big_mag = y;
            n_data.sml_mag = x;
        end else begin
            n_data.sign    = i_a_sign;
            n_data.big_mag = x;
            n_data.sml_mag = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/sbas_cell.sv
// One digit cell: adds or subtracts one BCD digit position with decimal
// carry or borrow and registers the transaction for the next cell. Uses sbas_pkg.
`timescale 1ns / 1ps

module sbas_cell
    import sbas_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_stage           i_data,
    output logic             o_valid,
    output t_stage           o_data
);

    localparam int BASE_W = IDX_W + 2;

    logic               r_valid;
    t_stage             r_data;
    t_stage             n_data;
    logic [BASE_W-1:0]  base;
    logic [DIG_W-1:0]   p;
    logic [DIG_W-1:0]   q;
    logic [DIG_W:0]     s;
    logic [DIG_W:0]     t;
    logic [DIG_W-1:0]   d;
    logic               cout;
    logic               used;

    always_comb begin
        base = {i_idx, 2'b00};
        p    = i_data.big_mag[base +: DIG_W];
        q    = i_data.sml_mag[base +: DIG_W];
        used = ({1'b0, i_idx} < (IDX_W + 1)'(i_data.len));
        s    = {1'b0, p} + {1'b0, q} + {{DIG_W{1'b0}}, i_data.carry};
        t    = {1'b0, q} + {{DIG_W{1'b0}}, i_data.carry};

        if (i_data.add) begin
            if (s >= (DIG_W + 1)'(10)) begin
                d    = DIG_W'(s - (DIG_W + 1)'(10));
                cout = 1'b1;
            end else begin
                d    = s[DIG_W-1:0];
                cout = 1'b0;
            end
        end else begin
            if ({1'b0, p} < t) begin
                d    = DIG_W'({1'b0, p} + (DIG_W + 1)'(10) - t);
                cout = 1'b1;
            end else begin
                d    = DIG_W'({1'b0, p} - t);
                cout = 1'b0;
            end
        end

        n_data = i_data;
        // Positions above the length keep the carry so the last cell sees the
        // carry out of the top used digit.
        if (used) begin
            n_data.sum[base +: DIG_W] = d;
            n_data.carry              = cout;
            n_data.bad                = i_data.bad || (p > DIG_W'(9)) || (q > DIG_W'(9));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/signed_bcd_add_sub.sv
// Top level; uses sbas_pkg, sbas_prep and sbas_cell.
// Each accepted input passes the prep register, then the row of digit cells,
// to the master side; throughput one transaction per cycle while results are
// taken. The rate is set by the digit cells, one per BCD digit, each handing its
// carry to the next cell as it moves on; a stalled output holds only the full
// stages behind it. Reset empties the row and sets the length to 16 digits.
`timescale 1ns / 1ps

module signed_bcd_add_sub
    import sbas_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LEN_W-1:0]      i_cfg_wdata,   // digits_in_use
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] a_sign, [64:1] a_digits, [65] b_sign, [129:66] b_digits, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] result_sign, [64:1] result_digits, [66:65] status, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [LEN_W-1:0]      r_len;
    logic                  prep_en;
    logic                  prep_valid;
    t_stage                prep_data;
    logic [MAX_DIGITS-1:0] cell_en;
    logic [MAX_DIGITS-1:0] cell_valid;
    t_stage                cell_data [MAX_DIGITS];
    t_stage                last;
    logic                  res_sign;
    logic [MAG_W-1:0]      res_digits;
    logic [1:0]            res_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(MAX_DIGITS);
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        cell_en[MAX_DIGITS-1] = !cell_valid[MAX_DIGITS-1] || m_axis_tready;
        for (int k = MAX_DIGITS - 2; k >= 0; k--) begin
            cell_en[k] = !cell_valid[k] || cell_en[k+1];
        end
        prep_en = !prep_valid || cell_en[0];
    end

    assign s_axis_tready = prep_en;

    sbas_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (prep_en),
        .i_valid    (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_a_sign   (s_axis_tdata[0]),
        .i_a_digits (s_axis_tdata[MAG_W:1]),
        .i_b_sign   (s_axis_tdata[MAG_W+1]),
        .i_b_digits (s_axis_tdata[2*MAG_W+1:MAG_W+2]),
        .i_cfg_len  (r_len),
        .o_valid    (prep_valid),
        .o_data     (prep_data)
    );

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        if (g == 0) begin : g_first
            sbas_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (IDX_W'(g)),
                .i_en    (cell_en[g]),
                .i_valid (prep_valid),
                .i_data  (prep_data),
                .o_valid (cell_valid[g]),
                .o_data  (cell_data[g])
            );
        end else begin : g_next
            sbas_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (IDX_W'(g)),
                .i_en    (cell_en[g]),
                .i_valid (cell_valid[g-1]),
                .i_data  (cell_data[g-1]),
                .o_valid (cell_valid[g]),
                .o_data  (cell_data[g])
            );
        end
    end

    assign last = cell_data[MAX_DIGITS-1];

    always_comb begin
        if (last.bad) begin
            res_sign   = 1'b1;
            res_digits = '0;
            res_status = ST_BAD;
        end else begin
            res_sign   = last.sign;
            res_digits = last.sum;
            res_status = (last.add && last.carry) ? ST_OVF : ST_OK;
        end
    end

    assign m_axis_tvalid = cell_valid[MAX_DIGITS-1];
    assign m_axis_tdata  = {{(OUT_DATA_W - MAG_W - 3){1'b0}}, res_status, res_digits, res_sign};

endmodule

### sv/sbas_check.sv
// Port-level checker for signed_bcd_add_sub, attached by a bind statement.
// Uses sbas_pkg.
`timescale 1ns / 1ps

module sbas_check
    import sbas_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // With the output empty the whole row can move, so input is taken.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

    // An invalid digit gives a positive zero.
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[MAG_W+2:MAG_W+1] == ST_BAD
        |-> m_axis_tdata[0] && m_axis_tdata[MAG_W:1] == '0)
        else $error("invalid-digit result not positive zero");

    // Status is one of the three codes.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[MAG_W+2:MAG_W+1] == ST_OK
                        || m_axis_tdata[MAG_W+2:MAG_W+1] == ST_OVF
                        || m_axis_tdata[MAG_W+2:MAG_W+1] == ST_BAD))
        else $error("unknown status code");

    // Reset empties the row.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind signed_bcd_add_sub sbas_check u_sbas_check (.*);

### tb/tb_signed_bcd_add_sub.sv
// Self-checking testbench for the signed BCD adder/subtractor.
// Drives random and corner-case operand pairs, predicts every result in a
// scoreboard class and compares field by field; depends on sbas_pkg and the RTL.
`timescale 1ns / 1ps

module tb_signed_bcd_add_sub;
    import sbas_pkg::*;

    localparam bit OP_ADD   = 1'b0;
    localparam bit OP_SUB   = 1'b1;
    localparam bit SIGN_POS = 1'b1;
    localparam bit SIGN_NEG = 1'b0;

    localparam int MAX_GAP         = 19;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int MAX_PRINTED     = 50;

    localparam logic [MAG_W-1:0] ALL_NINES = {MAX_DIGITS{4'h9}};

    typedef struct {
        bit             sign;
        bit [MAG_W-1:0] digits;
        bit [1:0]       status;
    } t_bcd_result;

    class bcd_scoreboard;
        bit [LEN_W-1:0] length_reg;
        t_bcd_result    pending_sums[$];
        int             errors;
        int             checked;
        int             overflows;
        int             invalids;
        int             zero_results;

        function new();
            length_reg = LEN_W'(MAX_DIGITS);
        endfunction

        function void set_length(bit [LEN_W-1:0] v);
            length_reg = v;
        endfunction

        // Out-of-range settings are clamped into 1..MAX_DIGITS.
        function int used_digits();
            if (length_reg == '0) begin
                return 1;
            end
            if (length_reg > LEN_W'(MAX_DIGITS)) begin
                return MAX_DIGITS;
            end
            return int'(length_reg);
        endfunction

        function int pending_count();
            return pending_sums.size();
        endfunction

        function t_bcd_result signed_bcd_result(bit func, bit a_sign, bit [MAG_W-1:0] a_raw,
                                                bit b_sign, bit [MAG_W-1:0] b_raw);
            t_bcd_result    r;
            int             len;
            int             d;
            int             q;
            bit [MAG_W-1:0] mask;
            bit [MAG_W-1:0] x;
            bit [MAG_W-1:0] y;
            bit [MAG_W-1:0] big;
            bit [MAG_W-1:0] sml;
            bit             eff_b_sign;
            bit             carry;

            len  = used_digits();
            mask = '1;
            mask = mask >> (DIG_W * (MAX_DIGITS - len));
            x = a_raw & mask;
            y = b_raw & mask;
            eff_b_sign = b_sign ^ func;
            r.sign   = a_sign;
            r.digits = '0;
            r.status = ST_OK;

            for (int i = 0; i < len; i++) begin
                if (x[i*DIG_W +: DIG_W] > 4'd9 || y[i*DIG_W +: DIG_W] > 4'd9) begin
                    r.sign   = 1'b1;
                    r.status = ST_BAD;
                    return r;
                end
            end

            carry = 1'b0;
            if (a_sign == eff_b_sign) begin
                for (int i = 0; i < len; i++) begin
                    d = int'(x[i*DIG_W +: DIG_W]) + int'(y[i*DIG_W +: DIG_W]) + int'(carry);
                    carry = (d >= 10);
                    if (carry) begin
                        d -= 10;
                    end
                    r.digits[i*DIG_W +: DIG_W] = d[3:0];
                end
                if (carry) begin
                    r.status = ST_OVF;
                end
            end else begin
                // Smaller magnitude comes off the larger; a tie keeps the first sign.
                big = x;
                sml = y;
                if (y > x) begin
                    big = y;
                    sml = x;
                    r.sign = eff_b_sign;
                end
                for (int i = 0; i < len; i++) begin
                    d = int'(big[i*DIG_W +: DIG_W]);
                    q = int'(sml[i*DIG_W +: DIG_W]) + int'(carry);
                    carry = (d < q);
                    d = carry ? d + 10 - q : d - q;
                    r.digits[i*DIG_W +: DIG_W] = d[3:0];
                end
            end
            return r;
        endfunction

        function void note_input(bit func, bit a_sign, bit [MAG_W-1:0] a,
                                 bit b_sign, bit [MAG_W-1:0] b);
            t_bcd_result r;

            r = signed_bcd_result(func, a_sign, a, b_sign, b);
            if (r.status == ST_OVF) begin
                overflows++;
            end else if (r.status == ST_BAD) begin
                invalids++;
            end else if (r.digits == '0) begin
                zero_results++;
            end
            pending_sums.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("[%0t] MISMATCH on result %0d: %s", $time, checked, msg);
            end
        endtask

        task check_result(bit [OUT_DATA_W-1:0] data);
            t_bcd_result got;
            t_bcd_result exp;

            got.sign   = data[0];
            got.digits = data[MAG_W:1];
            got.status = data[MAG_W+2:MAG_W+1];
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result sign=%0b digits=%h status=%0d",
                                          got.sign, got.digits, got.status));
                return;
            end
            exp = pending_sums.pop_front();
            if (got.sign !== exp.sign) begin
                report_mismatch($sformatf("sign %0b, expected %0b", got.sign, exp.sign));
            end
            if (got.digits !== exp.digits) begin
                report_mismatch($sformatf("digits %h, expected %h", got.digits, exp.digits));
            end
            if (got.status !== exp.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
            end
            checked++;
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    bcd_scoreboard sb = new();
    int            send_stretch = 0;
    int            recv_stretch = 0;
    int            cycle_count = 0;

    signed_bcd_add_sub dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending_count());
            $display("Some tests failed");
            $finish;
        end
    end

    // Random idle count per transaction, with occasional stretches of none.
    function automatic int draw_gap(ref int stretch);
        if (stretch > 0) begin
            stretch--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            stretch = $urandom_range(10, 40);
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic bit [MAG_W-1:0] random_bcd(int nd, bit junk_above);
        bit [MAG_W-1:0] v;

        v = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (i < nd) begin
                v[i*DIG_W +: DIG_W] = DIG_W'($urandom_range(0, 9));
            end else if (junk_above) begin
                v[i*DIG_W +: DIG_W] = DIG_W'($urandom_range(0, 15));
            end
        end
        return v;
    endfunction

    task automatic send_item(bit func, bit a_sign, bit [MAG_W-1:0] a,
                             bit b_sign, bit [MAG_W-1:0] b);
        int gap;

        gap = draw_gap(send_stretch);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - 2*MAG_W - 2){1'b0}}, b, b_sign, a, a_sign};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(func, a_sign, a, b_sign, b);
    endtask

    // At least one edge passes, so valid is never lowered and raised in one step.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    task automatic write_length(bit [LEN_W-1:0] v);
        hold_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_length(v);
    endtask

    task automatic random_item();
        int             len;
        int             kind;
        int             pos;
        bit             junk;
        bit [MAG_W-1:0] a;
        bit [MAG_W-1:0] b;

        len  = sb.used_digits();
        junk = ($urandom_range(0, 9) < 3);
        kind = $urandom_range(0, 99);
        a = random_bcd($urandom_range(1, len), junk);
        b = random_bcd($urandom_range(1, len), junk);
        if (kind < 6) begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
        end else if (kind < 16) begin
            b = a;
        end else if (kind < 26) begin
            a = ALL_NINES;
            b = random_bcd(len, junk);
        end else if (kind < 32) begin
            pos = $urandom_range(0, len - 1);
            if ($urandom_range(0, 1)) begin
                a[pos*DIG_W +: DIG_W] = DIG_W'($urandom_range(10, 15));
            end else begin
                b[pos*DIG_W +: DIG_W] = DIG_W'($urandom_range(10, 15));
            end
        end else if (kind < 50) begin
            // Full-length operands give long borrow and carry chains.
            a = random_bcd(len, junk);
            b = random_bcd(len, junk);
        end
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), a,
                  1'($urandom_range(0, 1)), b);
        if ($urandom_range(0, 199) == 0) begin
            hold_until_drained();
        end
    endtask

    initial begin
        int gap;

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap(recv_stretch);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
        end
    end

    initial begin
        bit [LEN_W-1:0] length_plan[10];

        length_plan = '{5'd1, 5'd0, 5'd17, 5'd31, 5'd2, 5'd9, 5'd15, 5'd16, 5'd5, 5'd12};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner cases at the reset length of sixteen digits.
        send_item(OP_ADD, SIGN_POS, '0, SIGN_POS, '0);
        send_item(OP_ADD, SIGN_POS, ALL_NINES, SIGN_POS, 64'h1);
        send_item(OP_ADD, SIGN_NEG, ALL_NINES, SIGN_NEG, ALL_NINES);
        send_item(OP_SUB, SIGN_POS, ALL_NINES, SIGN_NEG, 64'h1);
        send_item(OP_SUB, SIGN_POS, 64'h1234, SIGN_POS, 64'h1234);
        send_item(OP_ADD, SIGN_NEG, 64'h500, SIGN_POS, 64'h500);
        send_item(OP_ADD, SIGN_POS, ALL_NINES, SIGN_NEG, ALL_NINES);
        send_item(OP_SUB, SIGN_POS, 64'h1000, SIGN_POS, 64'h1);
        send_item(OP_SUB, SIGN_POS, 64'h1, SIGN_POS, 64'h1000);
        send_item(OP_ADD, SIGN_NEG, 64'h250, SIGN_POS, 64'h9999);
        send_item(OP_SUB, SIGN_NEG, '0, SIGN_NEG, ALL_NINES);
        send_item(OP_ADD, SIGN_POS, 64'h9A, SIGN_POS, 64'h1);
        send_item(OP_ADD, SIGN_NEG, 64'h1, SIGN_POS, 64'hF000_0000_0000_0000);
        send_item(OP_SUB, SIGN_NEG, '1, SIGN_POS, '1);
        send_item(OP_ADD, SIGN_POS, 64'h5, SIGN_POS, 64'h5);
        send_item(OP_SUB, SIGN_POS, 64'h8000_0000_0000_0000,
                  SIGN_NEG, 64'h8000_0000_0000_0000);
        send_item(OP_SUB, SIGN_NEG, 64'h9000_0000_0000_0001,
                  SIGN_NEG, 64'h0999_9999_9999_9999);
        send_item(OP_ADD, SIGN_POS, ALL_NINES, SIGN_NEG, '0);

        foreach (length_plan[p]) begin
            write_length(length_plan[p]);
            repeat (ITEMS_PER_PHASE) random_item();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results over %0d length settings, out-of-range ones included.",
                 sb.checked, $size(length_plan) + 1);
        $display("Predicted %0d decimal overflows, %0d invalid-digit operands, %0d zero sums.",
                 sb.overflows, sb.invalids, sb.zero_results);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
